[sv/mrf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, codes and the crc helper of the read master framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TX,
    ST_EVAL,
    ST_PAY_RD,
    ST_PAY_WR,
    ST_STATUS
  } mrf_state_t;

  // input item kinds
  localparam logic KIND_REQ = 1'b0;
  localparam logic KIND_RX  = 1'b1;

  // result item kinds
  localparam logic [1:0] OKIND_TX      = 2'd0;
  localparam logic [1:0] OKIND_PAYLOAD = 2'd1;
  localparam logic [1:0] OKIND_STATUS  = 2'd2;

  // frame status codes
  localparam logic [1:0] FST_OK        = 2'd0;
  localparam logic [1:0] FST_EXCEPTION = 2'd1;
  localparam logic [1:0] FST_CRC       = 2'd2;
  localparam logic [1:0] FST_LENGTH    = 2'd3;

  localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
  localparam int          EXC_BIT         = 7;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  DEV_ADDR_RESET  = 8'h01;

  // frame layout: address, function, byte count, payload, crc low, crc high
  localparam int HDR_BYTES = 3;
  localparam int TRL_BYTES = 2;
  localparam int MIN_FRAME = HDR_BYTES + TRL_BYTES;

  // one byte through the reflected crc-16
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int n = 0; n < 8; n++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[sv/mrf_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrf_in_if
// Input channel: read requests and received response bytes.
// ----------------------------------------------------------------------------
interface mrf_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] reg_address;
  logic [6:0]  reg_count;
  logic [7:0]  rx_byte;
  logic        rx_last;

  modport source (
    output valid, kind, reg_address, reg_count, rx_byte, rx_last,
    input  ready
  );

  modport sink (
    input  valid, kind, reg_address, reg_count, rx_byte, rx_last,
    output ready
  );
endinterface

[sv/mrf_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrf_out_if
// Result channel: transmit bytes, payload bytes and frame status.
// ----------------------------------------------------------------------------
interface mrf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [1:0] frame_status;
  logic       last;

  modport source (
    output valid, out_kind, out_byte, frame_status, last,
    input  ready
  );

  modport sink (
    input  valid, out_kind, out_byte, frame_status, last,
    output ready
  );
endinterface

[sv/modbus_rtu_read_master_framer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_read_master_framer
// Modbus RTU master framer for read holding registers transactions.
// ----------------------------------------------------------------------------
// A request beat (kind 0) produces the eight request bytes: device address,
// function 0x03, register address high and low, zero, register count, then
// crc low and high; one byte leaves per cycle while the output register is
// free. A response beat (kind 1) carries one received byte and is absorbed
// in ST_IDLE; the receive crc runs two bytes behind so the trailing pair
// can be compared at frame end. On the beat flagged last the block runs the
// checks in ST_EVAL (length, then exception bit, then crc) and, if all pass,
// reads each payload byte back from the payload ram in ST_PAY_RD (the ram's
// registered read) and loads it into the output register in ST_PAY_WR, then
// emits one status beat with last set. Frames shorter than five bytes or
// longer than MAX_FRAME report a length error. A request beat in the middle
// of a response drops the partial frame. The payload ram holds MAX_FRAME-5
// bytes and needs no clearing after reset. While results are being produced
// no input beat is taken; the last result may still wait in the output
// register when the next beat is accepted.
// ----------------------------------------------------------------------------
module modbus_rtu_read_master_framer #(
  parameter int MAX_FRAME = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  mrf_in_if.sink           in_ch,
  mrf_out_if.source        out_ch
);

  import mrf_pkg::*;

  localparam int STORE_DEPTH = MAX_FRAME - MIN_FRAME;
  localparam int CNT_W       = $clog2(MAX_FRAME + 1);
  localparam int AW          = $clog2(STORE_DEPTH);

  // control and receive state
  mrf_state_t       state_r, state_nxt;
  logic [7:0]       dev_addr_r;
  logic [15:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       dly0_r, dly0_nxt;
  logic [7:0]       dly1_r, dly1_nxt;
  logic [7:0]       fc_r, fc_nxt;
  logic             ovr_r, ovr_nxt;
  logic [2:0]       tx_idx_r, tx_idx_nxt;
  logic [CNT_W-1:0] pay_idx_r, pay_idx_nxt;
  logic [1:0]       status_r, status_nxt;

  // latched request fields
  logic [15:0]      addr_r, addr_nxt;
  logic [6:0]       rcnt_r, rcnt_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r;
  logic [7:0]       out_byte_r;
  logic [1:0]       out_status_r;
  logic             out_last_r;

  // beat being loaded into the output register
  logic             beat_ld;
  logic [1:0]       beat_kind;
  logic [7:0]       beat_byte;
  logic [1:0]       beat_status;
  logic             beat_last;

  logic             in_ready;
  logic             in_acc, req_acc, rx_acc;
  logic             slot_free;
  logic             room;
  logic [7:0]       tx_byte;
  logic [1:0]       eval_status;
  logic [CNT_W-1:0] pay_cnt;

  // payload ram ports
  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic             ram_rd_en;
  logic [7:0]       ram_rd_data;

  assign in_acc    = in_ch.valid && in_ready;
  assign req_acc   = in_acc && (in_ch.kind == KIND_REQ);
  assign rx_acc    = in_acc && (in_ch.kind == KIND_RX);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign room      = cnt_r < CNT_W'(MAX_FRAME);
  assign pay_cnt   = cnt_r - CNT_W'(MIN_FRAME);

  // payload bytes sit between the header and the crc trailer
  assign ram_wr_en   = rx_acc && room && (cnt_r >= CNT_W'(HDR_BYTES)) &&
                       (cnt_r < CNT_W'(MAX_FRAME - TRL_BYTES));
  assign ram_wr_addr = AW'(cnt_r - CNT_W'(HDR_BYTES));

  mrf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (in_ch.rx_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (pay_idx_r[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // request byte for the current transmit slot
  always_comb begin
    case (tx_idx_r)
      3'd0:    tx_byte = dev_addr_r;
      3'd1:    tx_byte = FC_READ_HOLDING;
      3'd2:    tx_byte = addr_r[15:8];
      3'd3:    tx_byte = addr_r[7:0];
      3'd4:    tx_byte = 8'h00;
      3'd5:    tx_byte = {1'b0, rcnt_r};
      3'd6:    tx_byte = crc_r[7:0];
      default: tx_byte = crc_r[15:8];
    endcase
  end

  // frame end checks, in priority order
  always_comb begin
    if (ovr_r || (cnt_r < CNT_W'(MIN_FRAME))) begin
      eval_status = FST_LENGTH;
    end else if (fc_r[EXC_BIT]) begin
      eval_status = FST_EXCEPTION;
    end else if (crc_r != {dly1_r, dly0_r}) begin
      eval_status = FST_CRC;
    end else begin
      eval_status = FST_OK;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req_acc) begin
          state_nxt = ST_TX;
        end else if (rx_acc && in_ch.rx_last) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_TX: begin
        if (slot_free && (tx_idx_r == 3'd7)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EVAL: begin
        if ((eval_status == FST_OK) && (pay_cnt != '0)) begin
          state_nxt = ST_PAY_RD;
        end else begin
          state_nxt = ST_STATUS;
        end
      end
      ST_PAY_RD: state_nxt = ST_PAY_WR;
      ST_PAY_WR: begin
        if (slot_free) begin
          state_nxt = (pay_idx_r + 1'b1 == pay_cnt) ? ST_STATUS : ST_PAY_RD;
        end
      end
      ST_STATUS: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready    = 1'b0;
    ram_rd_en   = 1'b0;
    beat_ld     = 1'b0;
    beat_kind   = OKIND_TX;
    beat_byte   = 8'h00;
    beat_status = FST_OK;
    beat_last   = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_TX: begin
        beat_ld   = slot_free;
        beat_kind = OKIND_TX;
        beat_byte = tx_byte;
        beat_last = (tx_idx_r == 3'd7);
      end
      ST_PAY_RD: ram_rd_en = 1'b1;
      ST_PAY_WR: begin
        beat_ld   = slot_free;
        beat_kind = OKIND_PAYLOAD;
        beat_byte = ram_rd_data;
      end
      ST_STATUS: begin
        beat_ld     = slot_free;
        beat_kind   = OKIND_STATUS;
        beat_status = status_r;
        beat_last   = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    crc_nxt     = crc_r;
    cnt_nxt     = cnt_r;
    dly0_nxt    = dly0_r;
    dly1_nxt    = dly1_r;
    fc_nxt      = fc_r;
    ovr_nxt     = ovr_r;
    tx_idx_nxt  = tx_idx_r;
    pay_idx_nxt = pay_idx_r;
    status_nxt  = status_r;
    addr_nxt    = addr_r;
    rcnt_nxt    = rcnt_r;

    if (req_acc) begin
      // a request drops any partial response
      crc_nxt    = CRC_INIT;
      cnt_nxt    = '0;
      dly0_nxt   = 8'h00;
      dly1_nxt   = 8'h00;
      fc_nxt     = 8'h00;
      ovr_nxt    = 1'b0;
      tx_idx_nxt = 3'd0;
      addr_nxt   = in_ch.reg_address;
      rcnt_nxt   = in_ch.reg_count;
    end else if (rx_acc) begin
      if (!room) begin
        ovr_nxt = 1'b1;
      end else begin
        if (cnt_r == CNT_W'(1)) begin
          fc_nxt = in_ch.rx_byte;
        end
        // crc lags two bytes behind the stream
        if (cnt_r >= CNT_W'(2)) begin
          crc_nxt = crc_feed(crc_r, dly0_r);
        end
        dly0_nxt = dly1_r;
        dly1_nxt = in_ch.rx_byte;
        cnt_nxt  = cnt_r + 1'b1;
      end
    end

    if ((state_r == ST_TX) && slot_free) begin
      tx_idx_nxt = tx_idx_r + 1'b1;
      if (tx_idx_r < 3'd6) begin
        crc_nxt = crc_feed(crc_r, tx_byte);
      end else if (tx_idx_r == 3'd7) begin
        crc_nxt = CRC_INIT;
      end
    end

    if (state_r == ST_EVAL) begin
      status_nxt  = eval_status;
      pay_idx_nxt = '0;
    end

    if ((state_r == ST_PAY_WR) && slot_free) begin
      pay_idx_nxt = pay_idx_r + 1'b1;
    end

    // frame end returns the receive side to its reset values
    if ((state_r == ST_STATUS) && slot_free) begin
      crc_nxt  = CRC_INIT;
      cnt_nxt  = '0;
      dly0_nxt = 8'h00;
      dly1_nxt = 8'h00;
      fc_nxt   = 8'h00;
      ovr_nxt  = 1'b0;
    end
  end

  assign out_valid_nxt = beat_ld ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dev_addr_r  <= DEV_ADDR_RESET;
      crc_r       <= CRC_INIT;
      cnt_r       <= '0;
      dly0_r      <= 8'h00;
      dly1_r      <= 8'h00;
      fc_r        <= 8'h00;
      ovr_r       <= 1'b0;
      tx_idx_r    <= 3'd0;
      pay_idx_r   <= '0;
      status_r    <= FST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      crc_r       <= crc_nxt;
      cnt_r       <= cnt_nxt;
      dly0_r      <= dly0_nxt;
      dly1_r      <= dly1_nxt;
      fc_r        <= fc_nxt;
      ovr_r       <= ovr_nxt;
      tx_idx_r    <= tx_idx_nxt;
      pay_idx_r   <= pay_idx_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        dev_addr_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    rcnt_r <= rcnt_nxt;
    if (beat_ld) begin
      out_kind_r   <= beat_kind;
      out_byte_r   <= beat_byte;
      out_status_r <= beat_status;
      out_last_r   <= beat_last;
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_kind     = out_kind_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.frame_status = out_status_r;
  assign out_ch.last         = out_last_r;

  // byte count saturates at the frame limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_FRAME))
    else $error("frame byte count beyond limit");

  // overrun only once the frame is full
  a_ovr_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovr_r |-> (cnt_r == CNT_W'(MAX_FRAME)))
    else $error("overrun with room left");

  // payload beats only follow a clean frame
  a_pay_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAY_WR) |-> (status_r == FST_OK))
    else $error("payload read after failed check");

  // status beat leaves the receive side cleared
  a_rx_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_STATUS) && slot_free) |=>
      ((cnt_r == '0) && (crc_r == CRC_INIT) && !ovr_r && (fc_r == 8'h00)))
    else $error("receive state not cleared at frame end");

endmodule

[sv/mrf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrf_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
module mrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the read master framer.
// ----------------------------------------------------------------------------
// Drives read requests and received response bytes through the input channel
// and predicts every request, payload and status beat with a local copy of
// the framer state. Output beats are compared field by field, in order, with
// the expected beats. A short directed table comes first, then random frames
// (well formed, corrupt, short, long, exception, or cut off by a
// request) under four device address settings. Both channels idle at random,
// and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import mrf_pkg::*;

  localparam int FRAME_MAX   = 16;
  localparam int STORE_DEPTH = FRAME_MAX - MIN_FRAME;
  localparam int PHASE_BEATS = 83;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic        kind;
    logic [15:0] reg_address;
    logic [6:0]  reg_count;
    logic [7:0]  rx_byte;
    logic        rx_last;
  } beat_t;

  typedef struct {
    logic [1:0] okind;
    logic [7:0] obyte;
    logic [1:0] status;
    logic       is_last;
  } result_t;

  // one row of the directed table; typed rows carry their status beat
  typedef struct packed {
    logic        kind;
    logic [15:0] addr;
    logic [6:0]  cnt;
    logic [7:0]  rxb;
    logic        rxl;
    logic        typed;
    logic [1:0]  want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [23] = '{
    // requests: address and count extremes, count above 125
    '{KIND_REQ, 16'h0000, 7'd0,   8'h00, 1'b0, 1'b0, FST_OK},
    '{KIND_REQ, 16'hFFFF, 7'd127, 8'hFF, 1'b1, 1'b0, FST_OK},
    '{KIND_REQ, 16'h1234, 7'd125, 8'h00, 1'b0, 1'b0, FST_OK},
    // one byte frame: too short
    '{KIND_RX,  16'h0000, 7'd0,   8'hFF, 1'b1, 1'b1, FST_LENGTH},
    // exception reply, crc never looked at
    '{KIND_RX,  16'h0000, 7'd0,   8'h01, 1'b0, 1'b0, FST_OK},
    '{KIND_RX,  16'h0000, 7'd0,   8'h83, 1'b0, 1'b0, FST_OK},
    '{KIND_RX,  16'h0000, 7'd0,   8'h02, 1'b0, 1'b0, FST_OK},
    '{KIND_RX,  16'h0000, 7'd0,   8'h00, 1'b0, 1'b0, FST_OK},
    '{KIND_RX,  16'h0000, 7'd0,   8'hFF, 1'b1, 1'b1, FST_EXCEPTION},
    // two byte reply with crc
    '{KIND_RX,  16'h0000, 7'd0,   8'h01, 1'b0, 1'b0, FST_OK},
    '{KIND_RX,  16'h0000, 7'd0,   8'h03, 1'b0, 1'b0, FST_OK},
    '{KIND_RX,  16'h0000, 7'd0,   8'h02, 1'b0, 1'b0, FST_OK},
    '{KIND_RX,  16'h0000, 7'd0,   8'h00, 1'b0, 1'b0, FST_OK},
    '{KIND_RX,  16'h0000, 7'd0,   8'h01, 1'b0, 1'b0, FST_OK},
    '{KIND_RX,  16'h0000, 7'd0,   8'h79, 1'b0, 1'b0, FST_OK},
    '{KIND_RX,  16'h0000, 7'd0,   8'h84, 1'b1, 1'b0, FST_OK},
    // partial reply dropped by a request
    '{KIND_RX,  16'h0000, 7'd0,   8'h01, 1'b0, 1'b0, FST_OK},
    '{KIND_RX,  16'h0000, 7'd0,   8'h03, 1'b0, 1'b0, FST_OK},
    '{KIND_REQ, 16'hABCD, 7'd1,   8'h00, 1'b0, 1'b0, FST_OK},
    // four byte frame: one short of the minimum
    '{KIND_RX,  16'h0000, 7'd0,   8'h01, 1'b0, 1'b0, FST_OK},
    '{KIND_RX,  16'h0000, 7'd0,   8'h03, 1'b0, 1'b0, FST_OK},
    '{KIND_RX,  16'h0000, 7'd0,   8'h00, 1'b0, 1'b0, FST_OK},
    '{KIND_RX,  16'h0000, 7'd0,   8'h00, 1'b1, 1'b1, FST_LENGTH}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [7:0] cfg_wr_data;

  mrf_in_if  in_ch ();
  mrf_out_if out_ch ();

  modbus_rtu_read_master_framer #(
    .MAX_FRAME (FRAME_MAX)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---- framer state as the bench sees it ----
  logic [7:0]  dev_addr;
  logic [15:0] rx_crc;        // runs two bytes behind the incoming frame
  int          rx_count;      // saturates at FRAME_MAX
  logic [7:0]  rx_hold [2];   // the two newest bytes, candidate crc pair
  logic [7:0]  rx_func;
  logic [7:0]  rx_payload [STORE_DEPTH];
  logic        rx_overrun;

  result_t    step_out [$];   // beats caused by the beat just accepted
  result_t    due_beats [$];  // beats still to come out, oldest first
  logic [7:0] rx_frame [$];   // response bytes being assembled
  int         beats_sent;
  int         error_cnt;
  int         cycle_cnt;
  logic       long_hold_req;

  function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = (r >> 1) ^ (CRC_POLY & {16{r[0]}});
    return r;
  endfunction

  function automatic void rx_restart();
    rx_crc     = CRC_INIT;
    rx_count   = 0;
    rx_hold[0] = 8'h00;
    rx_hold[1] = 8'h00;
    rx_func    = 8'h00;
    rx_overrun = 1'b0;
    foreach (rx_payload[i]) rx_payload[i] = 8'h00;
  endfunction

  // works out the result beats of one accepted input beat
  function automatic void predict_beat(beat_t b);
    logic [7:0]  req [8];
    logic [15:0] c;
    logic [1:0]  st;
    int          pos;
    int          i;
    step_out.delete();
    if (b.kind == KIND_REQ) begin
      req[0] = dev_addr;
      req[1] = FC_READ_HOLDING;
      req[2] = b.reg_address[15:8];
      req[3] = b.reg_address[7:0];
      req[4] = 8'h00;
      req[5] = {1'b0, b.reg_count};
      c = CRC_INIT;
      for (i = 0; i < 6; i++) c = crc16_byte(c, req[i]);
      req[6] = c[7:0];
      req[7] = c[15:8];
      // a request throws away any partial reply
      rx_restart();
      for (i = 0; i < 8; i++) step_out.push_back(result_t'{OKIND_TX, req[i], FST_OK, i == 7});
      return;
    end
    pos = rx_count;
    if (pos >= FRAME_MAX) begin
      rx_overrun = 1'b1;
    end else begin
      if (pos == 1) rx_func = b.rx_byte;
      if (pos >= HDR_BYTES && pos - HDR_BYTES < STORE_DEPTH)
        rx_payload[pos - HDR_BYTES] = b.rx_byte;
      if (pos >= TRL_BYTES) rx_crc = crc16_byte(rx_crc, rx_hold[0]);
      rx_hold[0] = rx_hold[1];
      rx_hold[1] = b.rx_byte;
      rx_count   = pos + 1;
    end
    if (!b.rx_last) return;
    // length first, then the exception bit, then the crc pair
    if (rx_overrun || rx_count < MIN_FRAME) st = FST_LENGTH;
    else if (rx_func[EXC_BIT]) st = FST_EXCEPTION;
    else if (rx_crc != {rx_hold[1], rx_hold[0]}) st = FST_CRC;
    else st = FST_OK;
    if (st == FST_OK) begin
      for (i = 0; i + MIN_FRAME < rx_count && i < STORE_DEPTH; i++)
        step_out.push_back(result_t'{OKIND_PAYLOAD, rx_payload[i], FST_OK, 1'b0});
    end
    step_out.push_back(result_t'{OKIND_STATUS, 8'h00, st, 1'b1});
    rx_restart();
  endfunction

  // sender gaps: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called at a falling edge, returns at the falling edge after the accept
  task automatic drive_beat(beat_t b, logic typed, logic [1:0] want_status);
    int gap;
    int i;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= b.kind;
    in_ch.reg_address <= b.reg_address;
    in_ch.reg_count   <= b.reg_count;
    in_ch.rx_byte     <= b.rx_byte;
    in_ch.rx_last     <= b.rx_last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_beat(b);
    beats_sent++;
    if (typed) begin
      due_beats.push_back(result_t'{OKIND_STATUS, 8'h00, want_status, 1'b1});
    end else begin
      for (i = 0; i < step_out.size(); i++) due_beats.push_back(step_out[i]);
    end
    @(negedge clk);
  endtask

  task automatic send_request();
    beat_t b;
    b.kind        = KIND_REQ;
    b.reg_address = 16'($urandom);
    b.reg_count   = 7'($urandom_range(0, 127));
    b.rx_byte     = 8'($urandom);
    b.rx_last     = 1'($urandom);
    drive_beat(b, 1'b0, FST_OK);
  endtask

  // sends rx_frame; close flags the final byte as end of frame
  task automatic send_rx_bytes(logic close);
    beat_t b;
    int    i;
    for (i = 0; i < rx_frame.size(); i++) begin
      b.kind        = KIND_RX;
      b.reg_address = 16'($urandom);
      b.reg_count   = 7'($urandom);
      b.rx_byte     = rx_frame[i];
      b.rx_last     = close && (i == rx_frame.size() - 1);
      drive_beat(b, 1'b0, FST_OK);
    end
  endtask

  // address, function, byte count, n data bytes, then a good crc
  function automatic void build_reply(int n, logic [7:0] fc);
    logic [15:0] c;
    int          i;
    rx_frame.delete();
    rx_frame.push_back($urandom_range(0, 1) ? dev_addr : 8'($urandom));
    rx_frame.push_back(fc);
    rx_frame.push_back(8'(n));
    for (i = 0; i < n; i++) rx_frame.push_back(8'($urandom));
    c = CRC_INIT;
    for (i = 0; i < rx_frame.size(); i++) c = crc16_byte(c, rx_frame[i]);
    rx_frame.push_back(c[7:0]);
    rx_frame.push_back(c[15:8]);
  endfunction

  function automatic logic [7:0] pick_func();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127)) : FC_READ_HOLDING;
  endfunction

  task automatic random_exchange();
    int r;
    int n;
    int idx;
    r = $urandom_range(0, 99);
    n = ($urandom_range(0, 3) == 0) ? STORE_DEPTH : $urandom_range(0, STORE_DEPTH);
    if (r < 16) begin
      send_request();
    end else if (r < 56) begin
      // good reply, full payload path
      build_reply(n, pick_func());
      send_rx_bytes(1'b1);
    end else if (r < 68) begin
      // one flipped bit somewhere in a good reply
      build_reply(n, pick_func());
      idx = $urandom_range(0, rx_frame.size() - 1);
      rx_frame[idx] = rx_frame[idx] ^ (8'h01 << $urandom_range(0, 7));
      send_rx_bytes(1'b1);
    end else if (r < 77) begin
      build_reply($urandom_range(0, 3), 8'h80 | 8'($urandom_range(0, 127)));
      send_rx_bytes(1'b1);
    end else if (r < 84) begin
      // under the minimum length
      rx_frame.delete();
      repeat ($urandom_range(1, MIN_FRAME - 1)) rx_frame.push_back(8'($urandom));
      send_rx_bytes(1'b1);
    end else if (r < 91) begin
      // past the maximum length, trailing bytes get dropped
      build_reply(STORE_DEPTH, pick_func());
      repeat ($urandom_range(1, 6)) rx_frame.push_back(8'($urandom));
      send_rx_bytes(1'b1);
    end else begin
      // reply cut short by a new request
      build_reply(n, pick_func());
      idx = $urandom_range(1, rx_frame.size() - 1);
      while (rx_frame.size() > idx) void'(rx_frame.pop_back());
      send_rx_bytes(1'b0);
      send_request();
    end
  endtask

  // drop valid and let the block drain completely
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_device_address(logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    dev_addr = v;
  endtask

  // ---- result side: random ready, one long hold-off on request ----
  initial begin : result_sink
    int stall_left;
    int free_left;
    int r;
    stall_left   = 0;
    free_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        stall_left    = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (stall_left == 0 && free_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 35) free_left = $urandom_range(10, 80);
        else if (r < 65) free_left = $urandom_range(1, 4);
        else if (r < 93) stall_left = $urandom_range(1, 3);
        else stall_left = $urandom_range(8, 40);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        free_left--;
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---- result check on every accepted output beat ----
  always @(posedge clk) begin
    result_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (due_beats.size() == 0) begin
        error_cnt++;
        if (error_cnt <= 10)
          $display("unexpected beat: kind %0d byte %02h status %0d last %0b",
                   out_ch.out_kind, out_ch.out_byte, out_ch.frame_status, out_ch.last);
      end else begin
        want = due_beats.pop_front();
        if (out_ch.out_kind !== want.okind || out_ch.out_byte !== want.obyte ||
            out_ch.frame_status !== want.status || out_ch.last !== want.is_last) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("mismatch (exp/got): kind %0d/%0d byte %02h/%02h status %0d/%0d last %0b/%0b",
                     want.okind, out_ch.out_kind, want.obyte, out_ch.out_byte,
                     want.status, out_ch.frame_status, want.is_last, out_ch.last);
        end
      end
    end
  end

  // ---- watchdog ----
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL modbus_rtu_read_master_framer");
    $finish;
  end

  // ---- stimulus ----
  initial begin : stimulus
    beat_t      b;
    int         k;
    int         goal;
    logic [7:0] phase_addr [4];
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 8'h00;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_REQ;
    in_ch.reg_address = 16'h0000;
    in_ch.reg_count   = 7'd0;
    in_ch.rx_byte     = 8'h00;
    in_ch.rx_last     = 1'b0;
    beats_sent        = 0;
    error_cnt         = 0;
    long_hold_req     = 1'b0;
    dev_addr          = DEV_ADDR_RESET;
    rx_restart();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table runs on the reset device address
    for (k = 0; k < $size(DIRECTED); k++) begin
      b.kind        = DIRECTED[k].kind;
      b.reg_address = DIRECTED[k].addr;
      b.reg_count   = DIRECTED[k].cnt;
      b.rx_byte     = DIRECTED[k].rxb;
      b.rx_last     = DIRECTED[k].rxl;
      drive_beat(b, DIRECTED[k].typed, DIRECTED[k].want);
    end
    settle();

    // random phases: address extremes first, then two random ones
    phase_addr[0] = 8'd0;
    phase_addr[1] = 8'd247;
    phase_addr[2] = 8'($urandom_range(2, 246));
    phase_addr[3] = 8'($urandom_range(0, 247));
    for (k = 0; k < 4; k++) begin
      write_device_address(phase_addr[k]);
      // output side stalls long enough to back the block up into the input
      if (k == 0) long_hold_req = 1'b1;
      goal = beats_sent + PHASE_BEATS;
      while (beats_sent < goal) random_exchange();
      settle();
    end

    repeat (20) @(posedge clk);
    if (error_cnt == 0 && due_beats.size() == 0) begin
      $display("PASS modbus_rtu_read_master_framer");
    end else begin
      $display("FAIL modbus_rtu_read_master_framer");
    end
    $finish;
  end

endmodule

[sim.f]
sv/mrf_pkg.sv
sv/mrf_in_if.sv
sv/mrf_out_if.sv
sv/mrf_ram.sv
sv/modbus_rtu_read_master_framer.sv
dv/testbench.sv
